// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the cipher core.
// Depends on nothing; included by modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that an implication holds at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

// ----- hw/rtl/aes256c_pkg.sv -----
// Package for the AES-256 CBC core: sizes, state codes and round functions.
// Depends on nothing; used by aes256_cbc_cipher_core and the testbench.
`timescale 1ns / 1ps
package aes256c_pkg;
   localparam int NumRounds = 14;
   localparam int KeyWords  = 60;
   localparam int RkAw      = 6;
   localparam int CsrAw     = 3;
   localparam int CntW      = 6;

   localparam logic [CsrAw-1:0] CSR_KEY0   = 3'd0;
   localparam logic [CsrAw-1:0] CSR_KEY1   = 3'd1;
   localparam logic [CsrAw-1:0] CSR_KEY2   = 3'd2;
   localparam logic [CsrAw-1:0] CSR_KEY3   = 3'd3;
   localparam logic [CsrAw-1:0] CSR_IV_HI  = 3'd4;
   localparam logic [CsrAw-1:0] CSR_IV_LO  = 3'd5;
   localparam logic [CsrAw-1:0] CSR_DECRYPT = 3'd6;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXPAND = 3'd1;
   localparam logic [2:0] ST_PRIME  = 3'd2;
   localparam logic [2:0] ST_ROUND  = 3'd3;
   localparam logic [2:0] ST_OUT    = 3'd4;

   typedef logic [127:0] block_type;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[x];
   endfunction

   function automatic logic [7:0] rsbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
      return t[x];
   endfunction

   function automatic logic [7:0] rcon(input logic [2:0] i);
      logic [7:0] r;
      unique case (i)
         3'd0: r = 8'h01;
         3'd1: r = 8'h02;
         3'd2: r = 8'h04;
         3'd3: r = 8'h08;
         3'd4: r = 8'h10;
         3'd5: r = 8'h20;
         3'd6: r = 8'h40;
         default: r = 8'h80;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] xt(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   // byte i of the block sits at bits 127-8i
   function automatic logic [7:0] gb(input block_type s, input int i);
      return s[127-8*i -: 8];
   endfunction

   function automatic block_type mix(input block_type s);
      block_type o;
      logic [7:0] a0, a1, a2, a3, t;
      o = s;
      for (int c = 0; c < 4; c++) begin
         a0 = gb(s, 4*c); a1 = gb(s, 4*c+1); a2 = gb(s, 4*c+2); a3 = gb(s, 4*c+3);
         t = a0 ^ a1 ^ a2 ^ a3;
         o[127-8*(4*c)   -: 8] = a0 ^ t ^ xt(a0 ^ a1);
         o[127-8*(4*c+1) -: 8] = a1 ^ t ^ xt(a1 ^ a2);
         o[127-8*(4*c+2) -: 8] = a2 ^ t ^ xt(a2 ^ a3);
         o[127-8*(4*c+3) -: 8] = a3 ^ t ^ xt(a3 ^ a0);
      end
      return o;
   endfunction

   function automatic block_type inv_mix(input block_type s);
      block_type o;
      logic [7:0] u, v;
      o = s;
      for (int c = 0; c < 4; c++) begin
         u = xt(xt(gb(s, 4*c) ^ gb(s, 4*c+2)));
         v = xt(xt(gb(s, 4*c+1) ^ gb(s, 4*c+3)));
         o[127-8*(4*c)   -: 8] = gb(s, 4*c) ^ u;
         o[127-8*(4*c+1) -: 8] = gb(s, 4*c+1) ^ v;
         o[127-8*(4*c+2) -: 8] = gb(s, 4*c+2) ^ u;
         o[127-8*(4*c+3) -: 8] = gb(s, 4*c+3) ^ v;
      end
      return mix(o);
   endfunction

   function automatic block_type sub_shift(input block_type s);
      block_type o;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            o[127-8*(r+4*c) -: 8] = sbox(gb(s, r + 4*((c + r) % 4)));
      return o;
   endfunction

   function automatic block_type inv_shift_sub(input block_type s);
      block_type o;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            o[127-8*(r + 4*((c + r) % 4)) -: 8] = rsbox(gb(s, r + 4*c));
      return o;
   endfunction
endpackage

// ----- hw/rtl/aes256_cbc_cipher_core.sv -----
// AES-256 CBC core with round key memory, chain register and stream ports.
// Depends on aes256c_pkg and assert_macros.svh.
`timescale 1ns / 1ps
// One 128-bit word in, one result word out, CBC chained, so words are
// processed one at a time. A word with first_block set first expands the
// key into the round key memory at one key word a cycle, four key words to
// a 128-bit entry, and uses the IV in place of the chain. After a word is
// accepted (and after the expansion, for a first word), the word passes
// through a prime state that reads the first round key, fifteen key
// additions carrying the fourteen rounds with one round key read each, and
// an output state. The input reopens only once the result is taken, so
// output stalls hold off the next word. The round key memory holds 15
// round keys of 128 bits; it is undefined until the first first_block word.
`include "assert_macros.svh"
module aes256_cbc_cipher_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // block_low, block_high
   input  logic         req_tuser,  // first_block
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,  // result_low, result_high
   input  logic         csr_we,
   input  logic [aes256c_pkg::CsrAw-1:0] csr_index,
   input  logic [63:0]  csr_wdata
);
   logic [63:0]  key_ff [4];
   logic [127:0] iv_ff;
   logic         dec_ff;
   logic [127:0] chain_ff;
   logic [2:0]   state_ff;
   logic [2:0]   state_in;
   logic [aes256c_pkg::CntW-1:0] cnt_ff;
   logic [aes256c_pkg::CntW-1:0] cnt_in;
   logic [127:0] st_ff, in_ff;
   logic [127:0] st_in;
   logic         first_ff;
   logic [255:0] win_ff;   // last eight key words during expansion
   logic         rvalid_ff;
   logic [127:0] rdata_ff;

   // round key memory, one round key per entry
   logic [127:0] rk_mem [aes256c_pkg::NumRounds+1];
   logic [3:0]   rk_ra;
   logic [127:0] rk_q;
   logic         rk_we;
   logic [3:0]   rk_wa;
   logic [127:0] rk_wd;

   logic [31:0]  nw;
   logic [255:0] win_in;
   logic [127:0] cur;

   always_ff @(posedge clock) begin
      if (rk_we) rk_mem[rk_wa] <= rk_wd;
      rk_q <= rk_mem[rk_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '{default: '0};
         iv_ff  <= '0;
         dec_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            aes256c_pkg::CSR_KEY0:    key_ff[0] <= csr_wdata;
            aes256c_pkg::CSR_KEY1:    key_ff[1] <= csr_wdata;
            aes256c_pkg::CSR_KEY2:    key_ff[2] <= csr_wdata;
            aes256c_pkg::CSR_KEY3:    key_ff[3] <= csr_wdata;
            aes256c_pkg::CSR_IV_HI:   iv_ff[127:64] <= csr_wdata;
            aes256c_pkg::CSR_IV_LO:   iv_ff[63:0] <= csr_wdata;
            aes256c_pkg::CSR_DECRYPT: dec_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // next key word from the sliding window; cnt holds word index i (8..59)
   always_comb begin
      logic [31:0] t;
      t = win_ff[31:0];
      if (cnt_ff[2:0] == 3'd0)
         t = aes256c_pkg::sub_word({t[23:0], t[31:24]})
            ^ {aes256c_pkg::rcon(3'(cnt_ff[5:3] - 3'd1)), 24'h0};
      else if (cnt_ff[2:0] == 3'd4)
         t = aes256c_pkg::sub_word(t);
      nw = win_ff[255:224] ^ t;
      win_in = {win_ff[223:0], nw};
   end

   assign req_tready = (state_ff == aes256c_pkg::ST_IDLE) && !rvalid_ff;
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {rdata_ff[63:0], rdata_ff[127:64]};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      st_in    = st_ff;
      rk_we    = 1'b0;
      rk_wa    = 4'd0;
      rk_wd    = '0;
      rk_ra    = 4'd0;
      cur      = 128'h0;
      unique case (state_ff)
         aes256c_pkg::ST_IDLE: begin
            rk_ra = dec_ff ? 4'(aes256c_pkg::NumRounds) : 4'd0;
            if (req_tvalid && req_tready) begin
               if (req_tuser) begin
                  state_in = aes256c_pkg::ST_EXPAND;
                  cnt_in   = 6'd8;
               end else begin
                  state_in = aes256c_pkg::ST_PRIME;
               end
            end
         end
         aes256c_pkg::ST_EXPAND: begin
            if (cnt_ff == 6'd8) begin
               rk_we = 1'b1; rk_wa = 4'd0; rk_wd = win_ff[255:128];
            end else if (cnt_ff == 6'd12) begin
               rk_we = 1'b1; rk_wa = 4'd1; rk_wd = win_ff[255:128];
            end else if (cnt_ff[1:0] == 2'd3) begin
               rk_we = 1'b1; rk_wa = 4'(cnt_ff[5:2]); rk_wd = win_in[127:0];
            end
            rk_ra = dec_ff ? 4'(aes256c_pkg::NumRounds) : 4'd0;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(aes256c_pkg::KeyWords - 1)) state_in = aes256c_pkg::ST_PRIME;
         end
         aes256c_pkg::ST_PRIME: begin
            rk_ra    = dec_ff ? 4'(aes256c_pkg::NumRounds) : 4'd0;
            st_in    = dec_ff ? in_ff : (in_ff ^ (first_ff ? iv_ff : chain_ff));
            cnt_in   = 6'd0;
            state_in = aes256c_pkg::ST_ROUND;
         end
         aes256c_pkg::ST_ROUND: begin
            // cnt counts key additions done; rk_q is the key for this one
            rk_ra = dec_ff ? 4'(6'(aes256c_pkg::NumRounds - 1) - cnt_ff)
                           : 4'(cnt_ff + 6'd1);
            cur = st_ff ^ rk_q;
            if (cnt_ff == 6'(aes256c_pkg::NumRounds)) begin
               st_in = cur;
               state_in = aes256c_pkg::ST_OUT;
            end else if (dec_ff) begin
               st_in = aes256c_pkg::inv_shift_sub(cnt_ff == 6'd0 ? cur
                                                  : aes256c_pkg::inv_mix(cur));
            end else begin
               st_in = aes256c_pkg::sub_shift(cur);
               if (cnt_ff != 6'(aes256c_pkg::NumRounds - 1))
                  st_in = aes256c_pkg::mix(st_in);
            end
            cnt_in = cnt_ff + 6'd1;
         end
         aes256c_pkg::ST_OUT: begin
            state_in = aes256c_pkg::ST_IDLE;
         end
         default: state_in = aes256c_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= aes256c_pkg::ST_IDLE;
         cnt_ff    <= '0;
         chain_ff  <= '0;
         rvalid_ff <= 1'b0;
         first_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (rvalid_ff && rsp_tready) rvalid_ff <= 1'b0;
         if (req_tvalid && req_tready) first_ff <= req_tuser;
         if (state_ff == aes256c_pkg::ST_OUT) begin
            rvalid_ff <= 1'b1;
            if (dec_ff) begin
               rdata_ff <= st_ff ^ (first_ff ? iv_ff : chain_ff);
               chain_ff <= in_ff;
            end else begin
               rdata_ff <= st_ff;
               chain_ff <= st_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
      if (req_tvalid && req_tready) begin
         in_ff  <= {req_tdata[63:0], req_tdata[127:64]};
         win_ff <= {key_ff[0], key_ff[1], key_ff[2], key_ff[3]};
      end else if (state_ff == aes256c_pkg::ST_EXPAND) begin
         win_ff <= win_in;
      end
   end

   `ASSERT_IMPL(a_no_accept_busy, clock, reset,
      state_ff != aes256c_pkg::ST_IDLE, !req_tready)
   `ASSERT_NEXT(a_out_valid, clock, reset,
      state_ff == aes256c_pkg::ST_OUT, rsp_tvalid)
   `ASSERT_IMPL(a_round_cnt, clock, reset,
      state_ff == aes256c_pkg::ST_ROUND, cnt_ff <= 6'(aes256c_pkg::NumRounds))
endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for the AES-256 CBC core: directed vectors, then random messages.
// Depends on aes256c_pkg and aes256_cbc_cipher_core; results are checked against
// known answers or a behavioral AES-256 CBC model kept inside the bench.
`timescale 1ns / 1ps
module testbench;
   typedef bit [127:0] blk_type;

   typedef struct {
      bit         mode;
      int         ksel;
      bit [63:0]  hi;
      bit [63:0]  lo;
      bit         first;
      bit         known;
      bit [127:0] want;
   } vec_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;
   logic         csr_we;
   logic [aes256c_pkg::CsrAw-1:0] csr_index;
   logic [63:0]  csr_wdata;

   aes256_cbc_cipher_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   bit [7:0]  fwd_box [256];
   bit [7:0]  inv_box [256];
   bit [31:0] round_keys [60];
   bit [63:0] key_reg [4];
   bit [63:0] iv_reg [2];
   bit        mode_reg;
   blk_type   chain;
   blk_type   pending_blocks [$];
   int        fails;
   int        send_idle_pct;
   int        recv_stall_pct;
   bit        hold_req;
   bit        hold_done;
   int        hold_cnt;

   always begin
      clock = 1'b1; #6;
      clock = 1'b0; #6;
   end

   function automatic bit [7:0] xtime(bit [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic bit [7:0] gf_mul(bit [7:0] a, bit [7:0] b);
      bit [7:0] p;
      p = 0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = xtime(a);
      end
      return p;
   endfunction

   function automatic bit [7:0] rotl8(bit [7:0] b, int n);
      return (b << n) | (b >> (8 - n));
   endfunction

   function automatic void build_boxes();
      bit [7:0] inv, p, sb;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h01;
         p = x[7:0];
         for (int e = 0; e < 8; e++) begin
            if (254 & (1 << e)) inv = gf_mul(inv, p);
            p = gf_mul(p, p);
         end
         if (x == 0) inv = 0;
         sb = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4) ^ 8'h63;
         fwd_box[x] = sb;
         inv_box[sb] = x[7:0];
      end
   endfunction

   function automatic bit [31:0] sub_word32(bit [31:0] w);
      return {fwd_box[w[31:24]], fwd_box[w[23:16]], fwd_box[w[15:8]], fwd_box[w[7:0]]};
   endfunction

   function automatic void expand_round_keys();
      bit [31:0] t;
      bit [7:0]  rc;
      rc = 8'h01;
      for (int i = 0; i < 4; i++) begin
         round_keys[2*i]   = key_reg[i][63:32];
         round_keys[2*i+1] = key_reg[i][31:0];
      end
      for (int i = 8; i < 60; i++) begin
         t = round_keys[i-1];
         if (i % 8 == 0) begin
            t = sub_word32({t[23:0], t[31:24]}) ^ {rc, 24'h0};
            rc = xtime(rc);
         end else if (i % 8 == 4) begin
            t = sub_word32(t);
         end
         round_keys[i] = round_keys[i-8] ^ t;
      end
   endfunction

   function automatic blk_type add_round_key(blk_type s, int r);
      for (int c = 0; c < 4; c++) s[127-32*c -: 32] ^= round_keys[4*r+c];
      return s;
   endfunction

   function automatic blk_type sub_shift_rows(blk_type s, bit inverse);
      blk_type n;
      int      a, b;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++) begin
            a = r + 4*c;
            b = r + 4*((c + r) % 4);
            if (inverse) n[127-8*b -: 8] = inv_box[s[127-8*a -: 8]];
            else n[127-8*a -: 8] = fwd_box[s[127-8*b -: 8]];
         end
      return n;
   endfunction

   function automatic blk_type mix_columns(blk_type s, bit inverse);
      bit [7:0] a [4];
      bit [7:0] t, u, v;
      for (int c = 0; c < 4; c++) begin
         for (int j = 0; j < 4; j++) a[j] = s[127-8*(4*c+j) -: 8];
         if (inverse) begin
            u = xtime(xtime(a[0] ^ a[2]));
            v = xtime(xtime(a[1] ^ a[3]));
            a[0] ^= u; a[1] ^= v; a[2] ^= u; a[3] ^= v;
         end
         t = a[0] ^ a[1] ^ a[2] ^ a[3];
         for (int j = 0; j < 4; j++)
            s[127-8*(4*c+j) -: 8] = a[j] ^ t ^ xtime(a[j] ^ a[(j+1)%4]);
      end
      return s;
   endfunction

   function automatic blk_type cbc_step(bit [63:0] hi, bit [63:0] lo, bit first);
      blk_type s;
      if (first) begin
         expand_round_keys();
         chain = {iv_reg[0], iv_reg[1]};
      end
      s = {hi, lo};
      if (mode_reg) begin
         s = add_round_key(s, 14);
         for (int r = 13; r >= 0; r--) begin
            s = sub_shift_rows(s, 1'b1);
            s = add_round_key(s, r);
            if (r > 0) s = mix_columns(s, 1'b1);
         end
         s ^= chain;
         chain = {hi, lo};
      end else begin
         s = add_round_key(s ^ chain, 0);
         for (int r = 1; r <= 14; r++) begin
            s = sub_shift_rows(s, 1'b0);
            if (r < 14) s = mix_columns(s, 1'b0);
            s = add_round_key(s, r);
         end
         chain = s;
      end
      return s;
   endfunction

   always @(negedge clock) begin
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_tready = 1'b0;
      end else if (hold_req && !hold_done) begin
         hold_done = 1'b1;
         hold_cnt = 300;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      blk_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_blocks.size() == 0) begin
            $display("%0t: result with none expected: %h", $time, rsp_tdata);
            fails++;
         end else begin
            want = pending_blocks.pop_front();
            if (rsp_tdata[63:0] !== want[127:64]) begin
               $display("%0t: result_high expected %h actual %h",
                        $time, want[127:64], rsp_tdata[63:0]);
               fails++;
            end
            if (rsp_tdata[127:64] !== want[63:0]) begin
               $display("%0t: result_low expected %h actual %h",
                        $time, want[63:0], rsp_tdata[127:64]);
               fails++;
            end
         end
      end
   end

   task automatic csr_write(logic [aes256c_pkg::CsrAw-1:0] idx, bit [63:0] data);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (pending_blocks.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic load_config(bit [63:0] k [4], bit [63:0] iv [2], bit mode);
      wait_idle();
      csr_write(aes256c_pkg::CSR_KEY0, k[0]);
      csr_write(aes256c_pkg::CSR_KEY1, k[1]);
      csr_write(aes256c_pkg::CSR_KEY2, k[2]);
      csr_write(aes256c_pkg::CSR_KEY3, k[3]);
      csr_write(aes256c_pkg::CSR_IV_HI, iv[0]);
      csr_write(aes256c_pkg::CSR_IV_LO, iv[1]);
      csr_write(aes256c_pkg::CSR_DECRYPT, {63'h0, mode});
      csr_write(3'd7, {$urandom, $urandom});
      key_reg = k;
      iv_reg = iv;
      mode_reg = mode;
   endtask

   task automatic send_word(bit [63:0] hi, bit [63:0] lo, bit first, bit known,
                            blk_type want);
      blk_type got;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid = 1'b1;
      req_tdata = {lo, hi};
      req_tuser = first;
      do @(posedge clock); while (!req_tready);
      got = cbc_step(hi, lo, first);
      pending_blocks.push_back(known ? want : got);
      @(negedge clock);
   endtask

   function automatic bit [63:0] rand_word();
      case ($urandom_range(5))
         0: return 64'h0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      vec_type   vecs [$];
      bit [63:0] k [4];
      bit [63:0] iv [2];
      int        cur_mode, cur_ksel;
      bit        first;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      fails = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_req = 0;
      hold_done = 0;
      hold_cnt = 0;
      build_boxes();
      mode_reg = 0;
      chain = '0;
      key_reg = '{default: 64'h0};
      iv_reg = '{default: 64'h0};
      repeat (8) @(negedge clock);
      reset = 1'b0;

      vecs = '{
         '{0, 0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1, 1,
           128'h8ea2b7ca516745bfeafc49904b496089},
         '{0, 0, 64'h0, 64'h0, 0, 0, 0},
         '{0, 0, '1, '1, 0, 0, 0},
         '{1, 0, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1, 1,
           128'h00112233445566778899aabbccddeeff},
         '{1, 0, '1, 64'h0, 0, 0, 0},
         '{0, 0, 64'h0, '1, 0, 0, 0},
         '{0, 1, 64'h0, 64'h0, 1, 1, 128'hdc95c078a2408989ad48a21492842087},
         '{0, 1, 64'h0, 64'h0, 0, 0, 0},
         '{0, 2, '1, '1, 1, 0, 0},
         '{0, 2, 64'h0123456789abcdef, 64'hfedcba9876543210, 0, 0, 0},
         '{1, 2, '1, '1, 1, 0, 0},
         '{1, 2, 64'h0, 64'h0, 0, 0, 0},
         '{1, 1, 64'h0, 64'h0, 1, 0, 0},
         '{0, 0, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 0, 0, 0},
         '{0, 0, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1, 0, 0}
      };
      cur_mode = -1;
      cur_ksel = -1;
      foreach (vecs[i]) begin
         if (vecs[i].mode != cur_mode || vecs[i].ksel != cur_ksel) begin
            case (vecs[i].ksel)
               0: k = '{64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                        64'h1011121314151617, 64'h18191a1b1c1d1e1f};
               1: k = '{default: 64'h0};
               default: k = '{default: '1};
            endcase
            if (vecs[i].ksel == 2) iv = '{default: '1};
            else iv = '{default: 64'h0};
            load_config(k, iv, vecs[i].mode);
            cur_mode = vecs[i].mode;
            cur_ksel = vecs[i].ksel;
         end
         send_word(vecs[i].hi, vecs[i].lo, vecs[i].first, vecs[i].known, vecs[i].want);
      end

      for (int seg = 0; seg < 10; seg++) begin
         for (int j = 0; j < 4; j++) k[j] = rand_word();
         iv[0] = rand_word();
         iv[1] = rand_word();
         load_config(k, iv, $urandom_range(1));
         case (seg % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         if (seg == 4) hold_req = 1'b1;
         for (int n = 0; n < 75; n++) begin
            first = (n == 0 && seg % 3 == 0) || ($urandom_range(7) == 0);
            send_word(rand_word(), rand_word(), first, 1'b0, '0);
            if (seg == 6 && n == 30) wait_idle();
         end
      end

      req_tvalid = 1'b0;
      while (pending_blocks.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fails == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
